### hdl/pmsa_pkg.sv
package pmsa_pkg;

    // field widths
    localparam int RAW_W = 16;
    localparam int MV_W = 16;
    localparam int PWR_W = 16;
    localparam int ERR_W = 2;
    localparam int CNT_W = 32;
    localparam int SUM_WIDTH_DEF = 32;

    // item modes
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_AVERAGE = 2'd1;
    localparam logic [1:0] MODE_ERRORS = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic REG_FULL_SCALE = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;
    localparam logic [15:0] FULL_SCALE_RESET = 16'd40;
    localparam logic [15:0] THRESHOLD_RESET = 16'd1500;

    // conversion constants
    localparam int VOLT_DROP = 5;
    localparam int VOLT_GAIN = 20000;
    localparam int VOLT_SHIFT = 10;
    localparam int POWER_DIV = 65535;
    localparam int POWER_SCALE = 10;
    localparam int POWER_MAX = 32767;
    localparam int POWER_MAG_NEG = 32768;
    localparam int MV_MAX = 65535;

    // error flag bits
    localparam logic [ERR_W-1:0] ERR_READ = 2'b01;
    localparam logic [ERR_W-1:0] ERR_LOW_BAT = 2'b10;

    // queue and divider sizes
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_LANES = 3;
    localparam int LANE_BAT = 0;
    localparam int LANE_SOL = 1;
    localparam int LANE_PWR = 2;

    // classified word handed from front to back
    typedef struct packed {
        logic [1:0]              mode;
        logic [MV_W-1:0]         bat_mv;
        logic [MV_W-1:0]         sol_mv;
        logic signed [PWR_W-1:0] bat_power;
        logic [ERR_W-1:0]        errs;
    } qword_t;

endpackage

### hdl/pmsa_front.sv
module pmsa_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [15:0]                  full_scale_power,
    input  logic [15:0]                  threshold_mv,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [pmsa_pkg::RAW_W-1:0]   bat_source_raw,
    input  logic                         bat_source_ok,
    input  logic [pmsa_pkg::RAW_W-1:0]   sol_source_raw,
    input  logic                         sol_source_ok,
    input  logic signed [pmsa_pkg::RAW_W-1:0] bat_power_raw,
    input  logic                         sense_negative,
    input  logic                         bat_power_ok,
    output logic                         push,
    output pmsa_pkg::qword_t             push_word,
    input  logic                         q_full
);
    import pmsa_pkg::*;

    localparam int VIN_W = RAW_W - VOLT_DROP;
    localparam int VPROD_W = VIN_W + 15;
    localparam int PPROD_W = 2 * RAW_W;
    localparam int PSCL_W = RAW_W + 3;

    // stage one registers
    logic               s1_valid_reg, s1_valid_next;
    logic [1:0]         s1_mode_reg;
    logic [VPROD_W-1:0] s1_bat_prod_reg, s1_sol_prod_reg;
    logic [PPROD_W-1:0] s1_pwr_prod_reg;
    logic               s1_pwr_neg_reg;
    logic               s1_bat_ok_reg, s1_sol_ok_reg, s1_pwr_ok_reg;

    logic               take, advance;
    logic [RAW_W-1:0]   pwr_abs;
    logic [VPROD_W-1:0] bat_prod, sol_prod;
    logic [PPROD_W-1:0] pwr_prod;

    logic [MV_W-1:0]    bat_mv, sol_mv;
    logic [RAW_W-1:0]   q0, quo;
    logic [RAW_W:0]     rsum;
    logic [PSCL_W-1:0]  pscaled, pscaled_neg;
    logic [PWR_W-1:0]   pwr;
    logic [ERR_W-1:0]   errs;

    // handshake
    assign advance = s1_valid_reg && ((s1_mode_reg == MODE_UNUSED) || !q_full);
    assign in_ready = !s1_valid_reg || advance;
    assign take = in_valid && in_ready;
    assign push = s1_valid_reg && (s1_mode_reg != MODE_UNUSED) && !q_full;

    // input multiplies
    always_comb
    begin
        pwr_abs = bat_power_raw[RAW_W-1] ? RAW_W'(-bat_power_raw) : RAW_W'(bat_power_raw);
        bat_prod = VPROD_W'(bat_source_raw[RAW_W-1:VOLT_DROP]) * VPROD_W'(VOLT_GAIN);
        sol_prod = VPROD_W'(sol_source_raw[RAW_W-1:VOLT_DROP]) * VPROD_W'(VOLT_GAIN);
        pwr_prod = PPROD_W'(pwr_abs) * PPROD_W'(full_scale_power);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_mode_reg <= mode;
            s1_bat_prod_reg <= bat_prod;
            s1_sol_prod_reg <= sol_prod;
            s1_pwr_prod_reg <= pwr_prod;
            s1_pwr_neg_reg <= bat_power_raw[RAW_W-1] ^ sense_negative;
            s1_bat_ok_reg <= bat_source_ok;
            s1_sol_ok_reg <= sol_source_ok;
            s1_pwr_ok_reg <= bat_power_ok;
        end
    end

    // millivolt scaling
    assign bat_mv = s1_bat_ok_reg ? s1_bat_prod_reg[VPROD_W-1:VOLT_SHIFT] : '0;
    assign sol_mv = s1_sol_ok_reg ? s1_sol_prod_reg[VPROD_W-1:VOLT_SHIFT] : '0;

    // power: divide by 65535 via shift plus one correction, scale by ten, saturate
    always_comb
    begin
        q0 = s1_pwr_prod_reg[PPROD_W-1:RAW_W];
        rsum = (RAW_W+1)'(s1_pwr_prod_reg[RAW_W-1:0]) + (RAW_W+1)'(q0);
        quo = q0 + RAW_W'(rsum >= (RAW_W+1)'(POWER_DIV));
        pscaled = PSCL_W'(quo) * PSCL_W'(POWER_SCALE);
        pscaled_neg = PSCL_W'(0) - pscaled;
        if (!s1_pwr_ok_reg)
            pwr = '0;
        else if (s1_pwr_neg_reg)
            pwr = (pscaled > PSCL_W'(POWER_MAG_NEG)) ? PWR_W'(POWER_MAG_NEG)
                                                    : pscaled_neg[PWR_W-1:0];
        else
            pwr = (pscaled > PSCL_W'(POWER_MAX)) ? PWR_W'(POWER_MAX) : pscaled[PWR_W-1:0];
    end

    // error classification
    always_comb
    begin
        errs = '0;
        if (!s1_bat_ok_reg || !s1_sol_ok_reg || !s1_pwr_ok_reg)
            errs = errs | ERR_READ;
        if (s1_bat_ok_reg && (bat_mv < threshold_mv))
            errs = errs | ERR_LOW_BAT;
    end

    always_comb
    begin
        push_word.mode = s1_mode_reg;
        push_word.bat_mv = bat_mv;
        push_word.sol_mv = sol_mv;
        push_word.bat_power = pwr;
        push_word.errs = errs;
    end

endmodule

### hdl/pmsa_queue.sv
module pmsa_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pmsa_pkg::qword_t push_word,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output pmsa_pkg::qword_t head
);
    import pmsa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    qword_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    assign full = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head = entry_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

endmodule

### hdl/pmsa_divider.sv
module pmsa_divider #(
    parameter int SUM_WIDTH = pmsa_pkg::SUM_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic [pmsa_pkg::DIV_LANES-1:0][SUM_WIDTH-1:0] dividend,
    input  logic [pmsa_pkg::CNT_W-1:0]                   divisor,
    output logic                                         busy,
    output logic                                         done,
    output logic [pmsa_pkg::DIV_LANES-1:0][SUM_WIDTH-1:0] quotient
);
    import pmsa_pkg::*;

    localparam int STEP_W = $clog2(SUM_WIDTH);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [STEP_W-1:0]                   step_reg, step_next;
    logic [CNT_W-1:0]                    divisor_reg;
    logic [DIV_LANES-1:0][SUM_WIDTH-1:0] quo_reg, quo_next;
    logic [DIV_LANES-1:0][CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W:0]                      shifted [DIV_LANES];
    logic                                ge [DIV_LANES];

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;

    // one restoring step per lane, all lanes share the step counter
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_LANES; i++)
        begin
            shifted[i] = {rem_reg[i], quo_reg[i][SUM_WIDTH-1]};
            ge[i] = shifted[i] >= {1'b0, divisor_reg};
            if (start)
            begin
                quo_next[i] = dividend[i];
                rem_next[i] = '0;
            end
            else if (busy_reg)
            begin
                quo_next[i] = {quo_reg[i][SUM_WIDTH-2:0], ge[i]};
                rem_next[i] = ge[i] ? CNT_W'(shifted[i] - {1'b0, divisor_reg})
                                    : shifted[i][CNT_W-1:0];
            end
        end
    end

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(SUM_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            divisor_reg <= divisor;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

### hdl/pmsa_back.sv
module pmsa_back #(
    parameter int SUM_WIDTH = pmsa_pkg::SUM_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          q_valid,
    input  pmsa_pkg::qword_t                              q_head,
    output logic                                          q_pop,
    output logic                                          div_start,
    output logic [pmsa_pkg::DIV_LANES-1:0][SUM_WIDTH-1:0] div_dividend,
    output logic [pmsa_pkg::CNT_W-1:0]                    div_divisor,
    input  logic                                          div_done,
    input  logic [pmsa_pkg::DIV_LANES-1:0][SUM_WIDTH-1:0] div_quotient,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [pmsa_pkg::MV_W-1:0]                     bat_mv,
    output logic [pmsa_pkg::MV_W-1:0]                     sol_mv,
    output logic signed [pmsa_pkg::PWR_W-1:0]             bat_power,
    output logic [pmsa_pkg::ERR_W-1:0]                    error_flags
);
    import pmsa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    localparam logic [SUM_WIDTH-1:0] USUM_MAX = {SUM_WIDTH{1'b1}};
    localparam logic [SUM_WIDTH-1:0] SSUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0] SSUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic [1:0]                  state_reg, state_next;
    logic [SUM_WIDTH-1:0]        bat_sum_reg, bat_sum_next;
    logic [SUM_WIDTH-1:0]        sol_sum_reg, sol_sum_next;
    logic [SUM_WIDTH-1:0]        power_sum_reg, power_sum_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [ERR_W-1:0]            sticky_reg, sticky_next;
    logic                        out_valid_reg, out_valid_next;
    logic [MV_W-1:0]             bat_mv_reg, sol_mv_reg;
    logic [PWR_W-1:0]            bat_power_reg;
    logic [ERR_W-1:0]            error_flags_reg;

    logic                        slot_free, load;
    logic [MV_W-1:0]             load_bat, load_sol;
    logic [PWR_W-1:0]            load_pwr;
    logic [ERR_W-1:0]            load_err;
    logic [SUM_WIDTH:0]          bat_add, sol_add, pwr_add;
    logic [MV_W-1:0]             avg_bat, avg_sol;
    logic [PWR_W-1:0]            avg_pwr;
    logic [SUM_WIDTH-1:0]        pwr_quo;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign bat_mv = bat_mv_reg;
    assign sol_mv = sol_mv_reg;
    assign bat_power = bat_power_reg;
    assign error_flags = error_flags_reg;

    // divider operands: voltage sums and power magnitude
    always_comb
    begin
        div_dividend[LANE_BAT] = bat_sum_reg;
        div_dividend[LANE_SOL] = sol_sum_reg;
        div_dividend[LANE_PWR] = power_sum_reg[SUM_WIDTH-1] ? (~power_sum_reg + 1'b1)
                                                            : power_sum_reg;
        div_divisor = count_reg;
    end

    // saturating sums for a sample word
    always_comb
    begin
        bat_add = {1'b0, bat_sum_reg} + (SUM_WIDTH+1)'(q_head.bat_mv);
        sol_add = {1'b0, sol_sum_reg} + (SUM_WIDTH+1)'(q_head.sol_mv);
        pwr_add = {power_sum_reg[SUM_WIDTH-1], power_sum_reg}
                + {{(SUM_WIDTH+1-PWR_W){q_head.bat_power[PWR_W-1]}}, q_head.bat_power};
    end

    // average saturation
    always_comb
    begin
        pwr_quo = div_quotient[LANE_PWR];
        avg_bat = (div_quotient[LANE_BAT] > SUM_WIDTH'(MV_MAX)) ? MV_W'(MV_MAX)
                                                               : div_quotient[LANE_BAT][MV_W-1:0];
        avg_sol = (div_quotient[LANE_SOL] > SUM_WIDTH'(MV_MAX)) ? MV_W'(MV_MAX)
                                                               : div_quotient[LANE_SOL][MV_W-1:0];
        if (power_sum_reg[SUM_WIDTH-1])
            avg_pwr = (pwr_quo > SUM_WIDTH'(POWER_MAG_NEG)) ? PWR_W'(POWER_MAG_NEG)
                                                           : PWR_W'(~pwr_quo + 1'b1);
        else
            avg_pwr = (pwr_quo > SUM_WIDTH'(POWER_MAX)) ? PWR_W'(POWER_MAX)
                                                       : pwr_quo[PWR_W-1:0];
    end

    // word processing sequencer
    always_comb
    begin
        state_next = state_reg;
        bat_sum_next = bat_sum_reg;
        sol_sum_next = sol_sum_reg;
        power_sum_next = power_sum_reg;
        count_next = count_reg;
        sticky_next = sticky_reg;
        q_pop = 1'b0;
        div_start = 1'b0;
        load = 1'b0;
        load_bat = '0;
        load_sol = '0;
        load_pwr = '0;
        load_err = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_head.mode)
                        MODE_SAMPLE:
                        begin
                            q_pop = 1'b1;
                            sticky_next = sticky_reg | q_head.errs;
                            bat_sum_next = bat_add[SUM_WIDTH] ? USUM_MAX
                                                              : bat_add[SUM_WIDTH-1:0];
                            sol_sum_next = sol_add[SUM_WIDTH] ? USUM_MAX
                                                              : sol_add[SUM_WIDTH-1:0];
                            if (pwr_add[SUM_WIDTH] != pwr_add[SUM_WIDTH-1])
                                power_sum_next = pwr_add[SUM_WIDTH] ? SSUM_MIN : SSUM_MAX;
                            else
                                power_sum_next = pwr_add[SUM_WIDTH-1:0];
                            if (count_reg != {CNT_W{1'b1}})
                                count_next = count_reg + 1'b1;
                        end
                        MODE_AVERAGE:
                        begin
                            if (count_reg != '0)
                            begin
                                q_pop = 1'b1;
                                div_start = 1'b1;
                                state_next = ST_DIV;
                            end
                            else if (slot_free)
                            begin
                                q_pop = 1'b1;
                                sticky_next = sticky_reg | q_head.errs;
                                load = 1'b1;
                                load_bat = q_head.bat_mv;
                                load_sol = q_head.sol_mv;
                                load_pwr = q_head.bat_power;
                            end
                        end
                        MODE_ERRORS:
                        begin
                            if (slot_free)
                            begin
                                q_pop = 1'b1;
                                load = 1'b1;
                                load_err = sticky_reg;
                                sticky_next = '0;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    load = 1'b1;
                    load_bat = avg_bat;
                    load_sol = avg_sol;
                    load_pwr = avg_pwr;
                    bat_sum_next = '0;
                    sol_sum_next = '0;
                    power_sum_next = '0;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bat_sum_reg <= '0;
            sol_sum_reg <= '0;
            power_sum_reg <= '0;
            count_reg <= '0;
            sticky_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bat_sum_reg <= bat_sum_next;
            sol_sum_reg <= sol_sum_next;
            power_sum_reg <= power_sum_next;
            count_reg <= count_next;
            sticky_reg <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bat_mv_reg <= load_bat;
            sol_mv_reg <= load_sol;
            bat_power_reg <= load_pwr;
            error_flags_reg <= load_err;
        end
    end

endmodule

### hdl/power_monitor_sample_averager_unit.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    mode, raw readings, read flags
// out       output     out_valid / out_ready  bat_mv, sol_mv, bat_power, error_flags
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// a sample word passes the stage one register and the queue before it is added to the sums;
// an error read or a readout with no samples is loaded into the output register from the queue head
// an average readout waits for the shared restoring divider, which gives one quotient bit per cycle
// for all three sums at once, and is then loaded into the output register
// reset clears sums, count, sticky flags and queue; full scale returns to 40 and threshold to 1500 mV
// a two-word queue parts the converting front from the accumulator; a full output register stalls
// the back on readout and error words, and stalls the front only once the queue is full
module power_monitor_sample_averager_unit #(
    parameter int SUM_WIDTH = pmsa_pkg::SUM_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [15:0]                         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic [pmsa_pkg::RAW_W-1:0]          bat_source_raw,
    input  logic                                bat_source_ok,
    input  logic [pmsa_pkg::RAW_W-1:0]          sol_source_raw,
    input  logic                                sol_source_ok,
    input  logic signed [pmsa_pkg::RAW_W-1:0]   bat_power_raw,
    input  logic                                sense_negative,
    input  logic                                bat_power_ok,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pmsa_pkg::MV_W-1:0]           bat_mv,
    output logic [pmsa_pkg::MV_W-1:0]           sol_mv,
    output logic signed [pmsa_pkg::PWR_W-1:0]   bat_power,
    output logic [pmsa_pkg::ERR_W-1:0]          error_flags
);
    import pmsa_pkg::*;

    logic [15:0]                         full_scale_reg;
    logic [15:0]                         threshold_reg;
    logic                                q_push, q_full, q_pop, q_valid;
    qword_t                              q_in, q_head;
    logic                                div_start, div_busy, div_done;
    logic [DIV_LANES-1:0][SUM_WIDTH-1:0] div_dividend, div_quotient;
    logic [CNT_W-1:0]                    div_divisor;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= FULL_SCALE_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FULL_SCALE: full_scale_reg <= cfg_data;
                REG_THRESHOLD:  threshold_reg <= cfg_data;
            endcase
        end
    end

    // front: conversion and classification
    pmsa_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .full_scale_power (full_scale_reg),
        .threshold_mv     (threshold_reg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .bat_source_raw   (bat_source_raw),
        .bat_source_ok    (bat_source_ok),
        .sol_source_raw   (sol_source_raw),
        .sol_source_ok    (sol_source_ok),
        .bat_power_raw    (bat_power_raw),
        .sense_negative   (sense_negative),
        .bat_power_ok     (bat_power_ok),
        .push             (q_push),
        .push_word        (q_in),
        .q_full           (q_full)
    );

    // word queue
    pmsa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_word  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // shared divider
    pmsa_divider #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // back: accumulation, readout and error reporting
    pmsa_back #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bat_mv       (bat_mv),
        .sol_mv       (sol_mv),
        .bat_power    (bat_power),
        .error_flags  (error_flags)
    );

`ifndef SYNTHESIS
    // queue never written when full
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("queue push while full");

    // back only pops a present word
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue pop while empty");

    // divider never restarted mid-division
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider started while busy");

    // divider engages after start
    assert property (@(posedge clk) disable iff (!rst_n) div_start |=> div_busy)
        else $error("divider did not start");
`endif

endmodule
